/* rtl/gbdt_pkg.sv */
// Package: shared types and codes for the graph traversal block.
`timescale 1ns / 1ps
package gbdt_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_BFS = 2'd1;
  localparam logic [1:0] OP_DFS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] first_vertex;
    logic [4:0] second_vertex;
  } in_item_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

/* rtl/gbdt_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gbdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/graph_bfs_dfs_traversal.sv */
// Top level: undirected graph store with breadth-first and depth-first search.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_item           | taken when start && !busy
//  result  | out_valid, out_item            | each item valid one cycle, no stall
//  config  | cfg_we, cfg_data               | written when cfg_we
//
// One item at a time. Add edge: the first vertex's list is compared against
// the second vertex one neighbor entry per cycle. Breadth-first: each vertex
// dequeued passes S_POP and S_POPW, then each neighbor entry walked S_NRD and
// S_NCHK. Depth-first: each neighbor entry passes S_POP, S_POPW, S_NRD and
// S_NCHK. Visited marks are flip-flops cleared at accept, so there is no sweep.
// Reset (rst_n low, synchronous) clears degrees, marks and control; the
// neighbor and work RAMs need no clearing. The receiver cannot stall: each
// result is shown for exactly one cycle.
`timescale 1ns / 1ps
module graph_bfs_dfs_traversal
  import gbdt_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [5:0] cfg_data
);
  localparam int VW = (MAX_VERTICES > 32) ? 6 : $clog2(MAX_VERTICES); // vertex idx bits
  localparam int PW = $clog2(MAX_VERTICES);       // list position bits
  localparam int DW = $clog2(MAX_VERTICES + 1);   // degree bits
  localparam int NA = VW + PW;                    // neighbor RAM address bits
  localparam int WD = 32;                         // work RAM depth
  localparam int WA = 5;
  localparam int EW = 5 + DW;                     // work entry: vertex, position
  localparam int LIMV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

  // States
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;  // issue read of neighbor a[i]
  localparam logic [3:0] S_SCANW = 4'd2;  // compare
  localparam logic [3:0] S_APPB  = 4'd3;  // append a to list b
  localparam logic [3:0] S_POP   = 4'd4;  // read work entry
  localparam logic [3:0] S_POPW  = 4'd5;  // work entry available
  localparam logic [3:0] S_NRD   = 4'd6;  // neighbor read issued
  localparam logic [3:0] S_NCHK  = 4'd7;  // check neighbor
  localparam logic [3:0] S_DONE  = 4'd8;  // emit deferred last

  logic [3:0] state_r, state_nxt;
  logic [5:0] vcount_r;
  logic [DW-1:0] degree_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic       is_dfs_r;
  logic [4:0] a_r, b_r;
  logic [DW-1:0] idx_r;           // scan index / remaining position
  logic [4:0] cur_r;              // vertex being expanded
  logic [5:0] head_r, tail_r;     // queue pointers / stack top in tail_r
  logic [4:0] pend_v_r;           // a result is held to learn if it is last
  logic       out_valid_r;
  out_item_t  out_item_r;

  // RAM ports
  logic          n_we;
  logic [NA-1:0] n_waddr, n_raddr;
  logic [4:0]    n_wdata, n_rdata;
  logic          w_we;
  logic [WA-1:0] w_waddr, w_raddr;
  logic [EW-1:0] w_wdata, w_rdata;

  gbdt_ram #(.WIDTH(5), .DEPTH(1 << NA)) u_nbr (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );
  gbdt_ram #(.WIDTH(EW), .DEPTH(WD)) u_work (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  // Effective vertex count
  logic [5:0] eff_n;
  always_comb begin
    eff_n = vcount_r;
    if (vcount_r > 6'(LIMV)) eff_n = 6'(LIMV);
  end

  function automatic logic [NA-1:0] naddr(input logic [4:0] v, input logic [DW-1:0] p);
    logic [VW-1:0] vv;
    logic [PW-1:0] pp;
    vv = VW'(v);
    pp = PW'(p);
    return {vv, pp};
  endfunction

  assign busy = (state_r != S_IDLE);

  // Control and data path
  logic [DW-1:0] deg_a, deg_b, deg_w;
  logic [4:0]    w_cur;
  logic          w_ok;
  assign deg_a   = degree_r[VW'(a_r)];
  assign deg_b   = degree_r[VW'(b_r)];
  assign w_cur   = n_rdata;
  assign deg_w   = degree_r[VW'(w_cur)];
  assign w_ok    = ({1'b0, w_cur} < eff_n) && !visited_r[VW'(w_cur)];

  logic       emit;
  out_item_t  emit_item;
  logic [1:0] in_op;
  logic [4:0] in_a, in_b;
  assign in_op = in_item.operation;
  assign in_a  = in_item.first_vertex;
  assign in_b  = in_item.second_vertex;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= 6'd32;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) degree_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      out_item_r  <= emit_item;
      if (cfg_we) vcount_r <= cfg_data;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r <= in_a;
            b_r <= in_b;
            idx_r <= '0;
            is_dfs_r <= (in_op == OP_DFS);
            if ((in_op == OP_BFS || in_op == OP_DFS) && ({1'b0, in_a} < eff_n)) begin
              // clear all marks and mark the start vertex
              visited_r <= MAX_VERTICES'(1) << VW'(in_a);
              pend_v_r <= in_a;
              head_r <= '0;
              tail_r <= 6'd1;
            end
          end
        end
        S_SCAN: ;
        S_SCANW: begin
          // an empty list never matches: its RAM data is meaningless
          if (deg_a == '0 || n_rdata != b_r) begin
            if (deg_a != '0 && idx_r + 1'b1 < deg_a) idx_r <= idx_r + 1'b1;
            else if (deg_a < DW'(MAX_VERTICES)) degree_r[VW'(a_r)] <= deg_a + 1'b1;
          end
        end
        S_APPB: begin
          if (deg_b < DW'(MAX_VERTICES)) degree_r[VW'(b_r)] <= deg_b + 1'b1;
        end
        S_POP: ;
        S_POPW: begin
          if (is_dfs_r) begin
            cur_r <= w_rdata[4:0];
            if (w_rdata[EW-1:5] == '0) tail_r <= tail_r - 1'b1;
            else idx_r <= w_rdata[EW-1:5] - 1'b1;
          end else begin
            cur_r <= w_rdata[4:0];
            idx_r <= degree_r[VW'(w_rdata[4:0])];
            head_r <= head_r + 1'b1;
          end
        end
        S_NRD: begin
          if (!is_dfs_r) idx_r <= idx_r - 1'b1;
        end
        S_NCHK: begin
          if (w_ok && tail_r < 6'(WD)) begin
            visited_r[VW'(w_cur)] <= 1'b1;
            pend_v_r <= w_cur;
            tail_r <= tail_r + 1'b1;
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // Next state, RAM control, result emission
  always_comb begin
    state_nxt = state_r;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0;
    n_raddr = naddr(a_r, idx_r);
    w_we = 1'b0; w_waddr = '0; w_wdata = '0;
    w_raddr = is_dfs_r ? WA'(tail_r - 1'b1) : WA'(head_r);
    emit = 1'b0;
    emit_item = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_ADD) begin
            if ({1'b0, in_a} >= eff_n || {1'b0, in_b} >= eff_n) begin
              emit = 1'b1;
              emit_item = '{vertex: 5'd0, status: ST_RANGE, last: 1'b1};
            end else if (degree_r[VW'(in_a)] == '0) begin
              // empty list: append directly
              state_nxt = S_SCANW;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (in_op == OP_BFS || in_op == OP_DFS) begin
            if ({1'b0, in_a} >= eff_n) begin
              emit = 1'b1;
              emit_item = '{vertex: 5'd0, status: ST_RANGE, last: 1'b1};
            end else begin
              w_we = 1'b1;
              w_waddr = '0;
              w_wdata = {degree_r[VW'(in_a)], in_a};
              state_nxt = S_POP;
            end
          end
        end
      end
      S_SCAN: begin
        n_raddr = naddr(a_r, idx_r);
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        // on an empty list the RAM data is meaningless: treat as no match
        if (deg_a != '0 && n_rdata == b_r) begin
          emit = 1'b1;
          emit_item = '{vertex: 5'd0, status: ST_DUP, last: 1'b1};
          state_nxt = S_IDLE;
        end else if (deg_a != '0 && idx_r + 1'b1 < deg_a) begin
          n_raddr = naddr(a_r, idx_r + 1'b1);
          state_nxt = S_SCANW;
        end else begin
          if (deg_a < DW'(MAX_VERTICES)) begin
            n_we = 1'b1; n_waddr = naddr(a_r, deg_a); n_wdata = b_r;
          end
          if (a_r != b_r) state_nxt = S_APPB;
          else begin
            emit = 1'b1;
            emit_item = '{vertex: 5'd0, status: ST_OK, last: 1'b1};
            state_nxt = S_IDLE;
          end
        end
      end
      S_APPB: begin
        if (deg_b < DW'(MAX_VERTICES)) begin
          n_we = 1'b1; n_waddr = naddr(b_r, deg_b); n_wdata = a_r;
        end
        emit = 1'b1;
        emit_item = '{vertex: 5'd0, status: ST_OK, last: 1'b1};
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if ((is_dfs_r && tail_r == '0) || (!is_dfs_r && head_r == tail_r))
          state_nxt = S_DONE;
        else state_nxt = S_POPW;
      end
      S_POPW: begin
        if (is_dfs_r) begin
          if (w_rdata[EW-1:5] == '0) state_nxt = S_POP;
          else begin
            w_we = 1'b1;
            w_waddr = WA'(tail_r - 1'b1);
            w_wdata = {w_rdata[EW-1:5] - 1'b1, w_rdata[4:0]};
            state_nxt = S_NRD;
          end
        end else begin
          if (degree_r[VW'(w_rdata[4:0])] == '0) state_nxt = S_POP;
          else state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        n_raddr = is_dfs_r ? naddr(cur_r, idx_r) : naddr(cur_r, idx_r - 1'b1);
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        if (w_ok && tail_r < 6'(WD)) begin
          // release the held result, hold the new one
          emit = 1'b1;
          emit_item = '{vertex: pend_v_r, status: ST_OK, last: 1'b0};
          w_we = 1'b1;
          w_waddr = WA'(tail_r);
          w_wdata = is_dfs_r ? {deg_w, w_cur} : {{DW{1'b0}}, w_cur};
        end
        if (is_dfs_r) state_nxt = S_POP;
        else if (idx_r == '0) state_nxt = S_POP;
        else state_nxt = S_NRD;
      end
      S_DONE: begin
        emit = 1'b1;
        emit_item = '{vertex: pend_v_r, status: ST_OK, last: 1'b1};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule
